// ===== src/bfg_pkg.sv =====
// Package for the BCD Fibonacci generator: digit widths, vector types,
// controller/datapath command and status structs and the decimal adder function.
// No dependencies.
`default_nettype none

package bfg_pkg;

  localparam int DIGITS  = 32;
  localparam int DIGIT_W = 4;
  localparam int INDEX_W = 8;
  localparam int RADIX   = 10;
  localparam int POS_W   = $clog2(DIGITS);

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [DIGITS-1:0][DIGIT_W-1:0] digit_vec_t;
  typedef logic [INDEX_W-1:0] index_t;

  typedef struct packed {
    logic load;
    logic seed_one;
    logic add;
    logic shift;
    logic emit;
    logic last;
  } bfg_cmd_t;

  typedef struct packed {
    logic top_zero;
    logic out_free;
  } bfg_status_t;

  // Carries are resolved by one binary add over the generate and propagate masks.
  function automatic digit_vec_t bcd_sum(input digit_vec_t a, input digit_vec_t b);
    logic [DIGITS-1:0][DIGIT_W:0] raw;
    logic [DIGITS-1:0]            gen;
    logic [DIGITS-1:0]            prop_any;
    logic [DIGITS:0]              chain;
    logic [DIGITS-1:0]            cin;
    logic [DIGIT_W:0]             tot;
    digit_vec_t                   res;
    for (int d = 0; d < DIGITS; d++) begin
      raw[d]      = {1'b0, a[d]} + {1'b0, b[d]};
      gen[d]      = raw[d] >= (DIGIT_W+1)'(RADIX);
      prop_any[d] = raw[d] >= (DIGIT_W+1)'(RADIX - 1);
    end
    chain = {1'b0, prop_any} + {1'b0, gen};
    cin   = chain[DIGITS-1:0] ^ prop_any ^ gen;
    for (int d = 0; d < DIGITS; d++) begin
      tot = raw[d] + {{DIGIT_W{1'b0}}, cin[d]};
      if (tot >= (DIGIT_W+1)'(RADIX)) begin
        res[d] = DIGIT_W'(tot - (DIGIT_W+1)'(RADIX));
      end else begin
        res[d] = tot[DIGIT_W-1:0];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/bfg_intf.sv =====
// Valid/ready channel interfaces for the index input and the digit output.
// Depends on bfg_pkg.
`default_nettype none

interface bfg_in_if import bfg_pkg::*;;
  logic   valid;
  logic   ready;
  index_t index_n;
  modport source (output valid, output index_n, input ready);
  modport sink (input valid, input index_n, output ready);
endinterface

interface bfg_out_if import bfg_pkg::*;;
  logic   valid;
  logic   ready;
  digit_t digit;
  logic   last;
  modport source (output valid, output digit, output last, input ready);
  modport sink (input valid, input digit, input last, output ready);
endinterface

`default_nettype wire

// ===== src/bfg_datapath.sv =====
// Datapath: the two BCD term registers, the decimal adder and the output register.
// Depends on bfg_pkg; driven by bfg_controller.
`default_nettype none

module bfg_datapath import bfg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  bfg_cmd_t    cmd_i,
  input  logic        out_ready_i,
  output bfg_status_t status_o,
  output logic        out_valid_o,
  output digit_t      out_digit_o,
  output logic        out_last_o
);

  digit_vec_t older_q, older_d;
  digit_vec_t newer_q, newer_d;
  digit_vec_t sum;
  logic       out_valid_q, out_valid_d;
  digit_t     out_digit_q, out_digit_d;
  logic       out_last_q, out_last_d;

  assign sum = bcd_sum(older_q, newer_q);

  always_comb begin
    older_d     = older_q;
    newer_d     = newer_q;
    out_valid_d = out_valid_q;
    out_digit_d = out_digit_q;
    out_last_d  = out_last_q;
    if (cmd_i.load) begin
      older_d = '0;
      newer_d = '0;
      newer_d[0] = {{(DIGIT_W-1){1'b0}}, cmd_i.seed_one};
    end else if (cmd_i.add) begin
      older_d = newer_q;
      newer_d = sum;
    end else if (cmd_i.shift) begin
      newer_d = {newer_q[DIGITS-2:0], {DIGIT_W{1'b0}}};
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_digit_d = newer_q[DIGITS-1];
      out_last_d  = cmd_i.last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    older_q     <= older_d;
    newer_q     <= newer_d;
    out_digit_q <= out_digit_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.top_zero = (newer_q[DIGITS-1] == '0);
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_digit_o       = out_digit_q;
  assign out_last_o        = out_last_q;

endmodule

`default_nettype wire

// ===== src/bfg_controller.sv =====
// Controller: sequences the additions, the leading-zero skip and the digit output.
// Depends on bfg_pkg; commands bfg_datapath.
`default_nettype none

module bfg_controller import bfg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  index_t      index_n_i,
  output logic        in_ready_o,
  input  bfg_status_t status_i,
  output bfg_cmd_t    cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StAdd  = 2'd1;
  localparam logic [1:0] StSkip = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]       state_q, state_d;
  index_t           remain_q, remain_d;
  logic [POS_W-1:0] pos_q, pos_d;

  always_comb begin
    state_d    = state_q;
    remain_d   = remain_q;
    pos_d      = pos_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.seed_one = (index_n_i != '0);
          remain_d       = index_n_i - INDEX_W'(1);
          pos_d          = POS_W'(DIGITS - 1);
          state_d        = (index_n_i >= INDEX_W'(2)) ? StAdd : StSkip;
        end
      end
      StAdd: begin
        cmd_o.add = 1'b1;
        remain_d  = remain_q - INDEX_W'(1);
        if (remain_q == INDEX_W'(1)) begin
          state_d = StSkip;
        end
      end
      StSkip: begin
        if (status_i.top_zero && (pos_q != '0)) begin
          cmd_o.shift = 1'b1;
          pos_d       = pos_q - POS_W'(1);
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.shift = 1'b1;
          cmd_o.last  = (pos_q == '0);
          if (pos_q == '0) begin
            state_d = StIdle;
          end else begin
            pos_d = pos_q - POS_W'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      remain_q <= '0;
      pos_q    <= '0;
    end else begin
      state_q  <= state_d;
      remain_q <= remain_d;
      pos_q    <= pos_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/bcd_fibonacci_generator_top.sv =====
// Top level of the BCD Fibonacci generator: controller plus datapath.
// Depends on bfg_pkg, bfg_intf, bfg_controller and bfg_datapath.
`default_nettype none

// Each transfer on in_i carries an index n; the block returns F(n) modulo
// 10^DIGITS on out_o as decimal digits, most significant first, without leading
// zeros, with last set on the final digit (zero gives a single digit 0). For n of
// two or more, the accepted index is followed by n-1 decimal additions, and the
// datapath adder completes one full-width addition per cycle. Leading zeros
// are then skipped at one digit per cycle, the controller moves on to its emit
// state, and each digit is loaded into the output register whenever that register
// is empty or its digit is being taken. The next index is taken once the last
// digit has been loaded into the output register.
module bcd_fibonacci_generator_top import bfg_pkg::*; (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  bfg_in_if.sink     in_i,
  bfg_out_if.source  out_o
);

  bfg_cmd_t    cmd;
  bfg_status_t status;

  bfg_controller u_controller (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .index_n_i  (in_i.index_n),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bfg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .out_ready_i (out_o.ready),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_digit_o (out_o.digit),
    .out_last_o  (out_o.last)
  );

`ifndef SYNTHESIS
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("Input accepted again straight after a transfer.");

  a_emit_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> status.out_free)
    else $error("Digit emitted over an untaken output.");

  a_digit_is_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.digit <= DIGIT_W'(RADIX - 1)))
    else $error("Output digit is not a decimal digit.");
`endif

endmodule

`default_nettype wire
